[design/wnp_pkg.sv]
package wnp_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int NUM_POINTS_RST = 1024;

    // cycles from trig unit input to clamped arc cosine
    localparam int ARC_LAT = 7;

    // quarter-wave polynomial coefficients, q30
    localparam logic [30:0] COEF_A = 31'd1686629713;
    localparam logic [30:0] COEF_B = 31'd688904866;
    localparam logic [30:0] COEF_C = 31'd76016977;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DRAIN,
        ST_ACOS,
        ST_DONE
    } wnp_state_t;

endpackage

[design/windowed_nearest_path_point.sv]
// query: bring the last index into range (more subtractions after n shrinks), then n points
// (first scan) or n/8 + 3n/8 points, one per cycle through the memory read and the trig
// pipeline, a drain, and an arc-cosine search of up to 16 steps, each waiting on the sine pipe
// load: no result; one item at a time, busy high while a query runs, rst_n clears
// the control state, the path store holds no reset value; results last one cycle, no stall
module windowed_nearest_path_point #(
    parameter int MAX_POINTS = wnp_pkg::MAX_POINTS_DEF,
    parameter int ANGLE_BITS = wnp_pkg::ANGLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [$clog2(MAX_POINTS)-1:0]   point_index,
    input  logic [ANGLE_BITS-1:0]           polar_angle,
    input  logic [ANGLE_BITS-1:0]           azimuth_angle,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [$clog2(MAX_POINTS):0]     cfg_data,
    output logic                            result_valid,
    output logic [$clog2(MAX_POINTS)-1:0]   nearest_index,
    output logic [ANGLE_BITS-1:0]           arc_distance
);
    import wnp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = AW + 1;
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QTR  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam int SIN_LAT = 5;

    wnp_state_t state_reg, state_next;

    logic [NW-1:0]        num_points_reg;
    logic [AW-1:0]        last_reg;
    logic                 track_reg;
    logic [ANGLE_BITS-1:0] qt_reg, qp_reg;
    logic [NW-1:0]        n_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic [NW-1:0]        left_reg;
    logic                 issue_reg;
    logic [AW-1:0]        issue_idx_reg;
    logic [AW-1:0]        idx_pipe [ARC_LAT];
    logic signed [31:0]   best_c_reg;
    logic [AW-1:0]        best_reg;
    logic                 have_reg;
    logic [ANGLE_BITS:0]  lo_reg, hi_reg;
    logic [2:0]           wait_reg;
    logic [ANGLE_BITS-1:0] dist_reg;

    logic [2*ANGLE_BITS-1:0] rdata;
    logic signed [31:0]   cos_arc;
    logic                 arc_valid;
    logic signed [31:0]   mid_cos;
    logic [ANGLE_BITS:0]  mid;
    logic [NW-1:0]        n_sat;
    logic                 stale;
    logic [NW-1:0]        eighth;
    logic [NW+1:0]        start_calc;
    logic [AW-1:0]        start_idx;
    logic                 we;
    logic                 query_go;

    // saturate the configured point count
    always_comb
    begin
        if (num_points_reg < NW'(8))
        begin
            n_sat = NW'(8);
        end
        else if (32'(num_points_reg) > 32'(MAX_POINTS))
        begin
            n_sat = NW'(MAX_POINTS);
        end
        else
        begin
            n_sat = NW'(num_points_reg);
        end
    end

    // window start: last index, already in range, stepped back by n/8
    assign stale      = (NW'(last_reg) >= n_sat);
    assign eighth     = n_sat >> 3;
    assign start_calc = (NW+2)'(last_reg) + (NW+2)'(n_sat) - (NW+2)'(eighth);
    assign start_idx  = (start_calc >= (NW+2)'(n_sat)) ? AW'(start_calc - (NW+2)'(n_sat))
                                                         : AW'(start_calc);

    assign we       = start && !busy && (mode == MODE_LOAD)
                      && (32'(point_index) < 32'(MAX_POINTS));
    assign query_go = start && !busy && (mode == MODE_QUERY);

    wnp_ram #(.WIDTH(2*ANGLE_BITS), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(point_index)),
        .wdata ({polar_angle, azimuth_angle}),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    wnp_arc #(.ANGLE_BITS(ANGLE_BITS)) u_arc (
        .clk       (clk),
        .rst_n     (rst_n),
        .t1        (qt_reg),
        .p1        (qp_reg),
        .t2        (rdata[2*ANGLE_BITS-1 -: ANGLE_BITS]),
        .p2        (rdata[ANGLE_BITS-1:0]),
        .in_valid  (issue_reg),
        .cos_arc   (cos_arc),
        .out_valid (arc_valid)
    );

    // dedicated sine pipe for the arc-cosine search
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_acos (
        .clk     (clk),
        .angle   (ANGLE_BITS'(mid) + QTR),
        .sin_q30 (mid_cos)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (query_go) state_next = ST_MOD;
            ST_MOD:   if (!stale) state_next = ST_SCAN;
            ST_SCAN:  if (left_reg == NW'(1)) state_next = ST_DRAIN;
            ST_DRAIN: if (!issue_reg && !arc_valid && wait_reg == 3'd0) state_next = ST_ACOS;
            ST_ACOS:  if (lo_reg >= hi_reg) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        result_valid = (state_reg == ST_DONE);
    end

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign nearest_index = best_reg;
    assign arc_distance  = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_points_reg <= NW'(NUM_POINTS_RST);
            last_reg       <= '0;
            track_reg      <= 1'b0;
            issue_reg      <= 1'b0;
            have_reg       <= 1'b0;
            left_reg       <= '0;
            wait_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                num_points_reg <= cfg_data;
            end
            issue_reg <= (state_reg == ST_SCAN);
            case (state_reg)
                ST_IDLE:
                begin
                    have_reg <= 1'b0;
                    wait_reg <= 3'(ARC_LAT);
                end
                ST_MOD:
                begin
                    // pull a stale last index into range, one subtraction a cycle
                    left_reg <= track_reg ? (eighth + NW'((32'(n_sat) * 3) >> 3)) : n_sat;
                    if (stale)
                    begin
                        last_reg <= last_reg - AW'(n_sat);
                    end
                end
                ST_SCAN:
                begin
                    left_reg <= left_reg - NW'(1);
                end
                ST_DRAIN:
                begin
                    wait_reg <= (wait_reg == 3'd0) ? 3'd0 : wait_reg - 3'd1;
                end
                ST_ACOS:
                begin
                    wait_reg <= (wait_reg == 3'd0) ? 3'(SIN_LAT) : wait_reg - 3'd1;
                end
                ST_DONE:
                begin
                    last_reg  <= best_reg;
                    track_reg <= 1'b1;
                end
                default:
                begin
                    wait_reg <= '0;
                end
            endcase
            // strict improvement keeps the first on a tie
            if (arc_valid && (!have_reg || cos_arc > best_c_reg))
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_pipe[0] <= issue_idx_reg;
        for (int k = 1; k < ARC_LAT; k++)
        begin
            idx_pipe[k] <= idx_pipe[k-1];
        end
        if (state_reg == ST_IDLE)
        begin
            qt_reg      <= polar_angle;
            qp_reg      <= azimuth_angle;
            n_reg       <= n_sat;
            lo_reg      <= '0;
            hi_reg      <= (ANGLE_BITS+1)'(HALF);
        end
        if (state_reg == ST_MOD)
        begin
            rd_addr_reg <= track_reg ? start_idx : '0;
        end
        if (state_reg == ST_SCAN)
        begin
            issue_idx_reg <= rd_addr_reg;
            rd_addr_reg   <= (NW'(rd_addr_reg) + NW'(1) == n_reg) ? '0 : rd_addr_reg + AW'(1);
        end
        if (arc_valid && (!have_reg || cos_arc > best_c_reg))
        begin
            best_c_reg <= cos_arc;
            best_reg   <= idx_pipe[ARC_LAT-1];
        end
        if (state_reg == ST_ACOS && wait_reg == 3'd0 && lo_reg < hi_reg)
        begin
            if (mid_cos <= best_c_reg)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + (ANGLE_BITS+1)'(1);
            end
        end
        if (state_reg == ST_ACOS)
        begin
            dist_reg <= ANGLE_BITS'(lo_reg);
        end
    end

endmodule

[design/wnp_ram.sv]
module wnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/wnp_sin.sv]
module wnp_sin #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic [ANGLE_BITS-1:0]   angle,
    output logic signed [31:0]      sin_q30
);
    import wnp_pkg::*;

    // five-stage pipelined polynomial sine, q30 out
    logic [1:0]  q0_reg, q1_reg, q2_reg, q3_reg, q4_reg;
    logic [30:0] z0_reg, z1_reg, z2_reg, z3_reg;
    logic [30:0] zsq_reg;
    logic [30:0] t1_reg, t2_reg;
    logic [30:0] zsq2_reg;
    logic [30:0] p_reg;
    logic [61:0] zz_full, t1_full, t2_full, p_full;
    logic [30:0] z_next;
    logic [30:0] r_ext;

    assign r_ext = 31'(angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    assign z_next = angle[ANGLE_BITS-2] ? (ONE_Q30[30:0] - r_ext) : r_ext;

    assign zz_full = 62'(z0_reg) * 62'(z0_reg);
    assign t1_full = 62'(COEF_C) * 62'(zsq_reg);
    assign t2_full = 62'(COEF_B - t1_reg) * 62'(zsq2_reg);
    assign p_full  = 62'(COEF_A - t2_reg) * 62'(z3_reg);

    always_ff @(posedge clk)
    begin
        q0_reg   <= angle[ANGLE_BITS-1 -: 2];
        z0_reg   <= z_next;
        q1_reg   <= q0_reg;
        z1_reg   <= z0_reg;
        zsq_reg  <= zz_full[60:30];
        q2_reg   <= q1_reg;
        z2_reg   <= z1_reg;
        zsq2_reg <= zsq_reg;
        t1_reg   <= t1_full[60:30];
        q3_reg   <= q2_reg;
        z3_reg   <= z2_reg;
        t2_reg   <= t2_full[60:30];
        q4_reg   <= q3_reg;
        p_reg    <= (p_full[61:30] > 32'(ONE_Q30)) ? ONE_Q30[30:0] : p_full[60:30];
    end

    assign sin_q30 = q4_reg[1] ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});

endmodule

[design/wnp_arc.sv]
module wnp_arc #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ANGLE_BITS-1:0]  t1,
    input  logic [ANGLE_BITS-1:0]  p1,
    input  logic [ANGLE_BITS-1:0]  t2,
    input  logic [ANGLE_BITS-1:0]  p2,
    input  logic                   in_valid,
    output logic signed [31:0]     cos_arc,
    output logic                   out_valid
);
    import wnp_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic signed [31:0] ct1, st1, ct2, st2, cdp;
    logic signed [31:0] a_reg, b_reg, cdp_reg, c_reg;
    logic signed [31:0] m1, m2, m3;
    logic signed [32:0] sum;
    logic [ARC_LAT-1:0] vld_reg;

    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_ct1 (.clk(clk), .angle(t1 + QTR), .sin_q30(ct1));
    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_st1 (.clk(clk), .angle(t1), .sin_q30(st1));
    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_ct2 (.clk(clk), .angle(t2 + QTR), .sin_q30(ct2));
    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_st2 (.clk(clk), .angle(t2), .sin_q30(st2));
    wnp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cdp (.clk(clk), .angle(p2 - p1 + QTR), .sin_q30(cdp));

    // q30 product truncated toward zero
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ma, mb;
        logic [63:0] m;
        logic        neg;
        neg = a[31] ^ b[31];
        ma  = a[31] ? 32'(-a) : 32'(a);
        mb  = b[31] ? 32'(-b) : 32'(b);
        m   = 64'(ma) * 64'(mb);
        return neg ? -$signed(m[61:30]) : $signed(m[61:30]);
    endfunction

    assign m1  = qmul(ct1, ct2);
    assign m2  = qmul(st1, st2);
    assign m3  = qmul(b_reg, cdp_reg);
    assign sum = 33'(a_reg) + 33'(m3);

    always_ff @(posedge clk)
    begin
        a_reg   <= m1;
        b_reg   <= m2;
        cdp_reg <= cdp;
        if (sum > 33'sd1073741824)
        begin
            c_reg <= 32'sd1073741824;
        end
        else if (sum < -33'sd1073741824)
        begin
            c_reg <= -32'sd1073741824;
        end
        else
        begin
            c_reg <= 32'(sum);
        end
    end

    // valid travels alongside the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ARC_LAT-2:0], in_valid};
        end
    end

    assign cos_arc   = c_reg;
    assign out_valid = vld_reg[ARC_LAT-1];

endmodule

[design/wnp_checker.sv]
module wnp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic cfg_ready,
    input logic result_valid,
    input logic [15:0] arc_distance
);

    // a result only comes while busy
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result without a query");

    // a result ends the query
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !busy)
        else $error("busy after result");

    // a load never raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |=> !busy)
        else $error("load made the block busy");

    // distance never beyond half a turn
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (arc_distance <= 16'd32768))
        else $error("distance out of range");

    // config taken only while idle
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready |-> !busy)
        else $error("config open while busy");

endmodule

bind windowed_nearest_path_point wnp_checker u_wnp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .arc_distance (arc_distance)
);
